// ===== design/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the bandwidth probe controller
// Phase encoding, fixed field widths and tuning constants of the probe logic.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned FieldW = 32;
  localparam int unsigned PhaseW = 2;

  // Probe tuning constants
  localparam int unsigned WaitTimeoutMs = 1000;
  localparam int unsigned DefaultMaxBps = 5000000;
  localparam int unsigned FurtherNum    = 7;    // 70 percent as 7/10
  localparam int unsigned FurtherDen    = 10;
  localparam int unsigned DropNum       = 66;
  localparam int unsigned DropDen       = 100;

  // Event kinds
  localparam logic FUNC_LIMITS   = 1'b0;
  localparam logic FUNC_ESTIMATE = 1'b1;

  // Controller phase
  typedef enum logic [PhaseW-1:0] {
    PH_INIT = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  // Per-event result flags
  typedef struct packed {
    logic probe_valid;
    logic status;
  } bpc_flags_t;

endpackage

// ===== design/bpc_if.sv =====
// ----------------------------------------------------------------------------
// bpc_in_if / bpc_out_if: event and result channels
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bpc_in_if import bpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [FieldW-1:0] now_ms;
  logic [FieldW-1:0] estimate_bps;
  logic [FieldW-1:0] min_bps;
  logic [FieldW-1:0] start_bps;
  logic [FieldW-1:0] max_bps;

  modport source (
    output valid, func, now_ms, estimate_bps, min_bps, start_bps, max_bps,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, estimate_bps, min_bps, start_bps, max_bps,
    output ready
  );
endinterface

interface bpc_out_if import bpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              probe_valid;
  logic [FieldW-1:0] probe_bps;
  logic              status;
  logic [PhaseW-1:0] phase_now;
  logic [FieldW-1:0] drop_time_ms;
  logic [FieldW-1:0] drop_prior_bps;

  modport source (
    output valid, probe_valid, probe_bps, status, phase_now, drop_time_ms,
           drop_prior_bps,
    input  ready
  );
  modport sink (
    input  valid, probe_valid, probe_bps, status, phase_now, drop_time_ms,
           drop_prior_bps,
    output ready
  );
endinterface

// ===== design/bandwidth_probe_controller_unit.sv =====
// ----------------------------------------------------------------------------
// bandwidth_probe_controller_unit: exponential bandwidth probe controller
// Takes rate-limit and estimate events and emits one result per event.
//
//   channel  dir  transaction
//   in_i     in   one event: func, now_ms, estimate_bps, min/start/max_bps
//   out_o    out  one result: probe_valid, probe_bps, status, phase_now,
//                 drop_time_ms, drop_prior_bps
//
// Each event passes through the input register and then the result
// register, one event per cycle while out_o does not stall. The state
// update and the result are computed in one pass of bpc_core. A stall on
// out_o holds the result register and backs up into the input register.
// Reset clears the controller state to the init phase.
// ----------------------------------------------------------------------------
module bandwidth_probe_controller_unit import bpc_pkg::*; #(
  parameter int unsigned RATE_WIDTH = 32,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o
);

  // input register
  logic                  in_vld_q;
  logic                  func_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [RATE_WIDTH-1:0] est_q;
  logic [RATE_WIDTH-1:0] min_q;
  logic [RATE_WIDTH-1:0] start_q;
  logic [RATE_WIDTH-1:0] max_q;

  // controller state
  phase_e                phase_q,      phase_d;
  logic [RATE_WIDTH-1:0] further_q,    further_d;
  logic [TIME_WIDTH-1:0] probe_time_q, probe_time_d;
  logic [RATE_WIDTH-1:0] last_est_q,   last_est_d;
  logic [RATE_WIDTH-1:0] start_rate_q, start_rate_d;
  logic [RATE_WIDTH-1:0] max_rate_q,   max_rate_d;
  logic [TIME_WIDTH-1:0] drop_time_q,  drop_time_d;
  logic [RATE_WIDTH-1:0] drop_prior_q, drop_prior_d;

  // result register
  logic                  out_vld_q;
  bpc_flags_t            flags_q,      flags_d;
  logic [RATE_WIDTH-1:0] probe_q,      probe_d;

  logic adv;
  logic fire;

  // Handshake: advance when the result slot is free or being taken
  assign adv        = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q  <= in_i.func;
      now_q   <= TIME_WIDTH'(in_i.now_ms);
      est_q   <= RATE_WIDTH'(in_i.estimate_bps);
      min_q   <= RATE_WIDTH'(in_i.min_bps);
      start_q <= RATE_WIDTH'(in_i.start_bps);
      max_q   <= RATE_WIDTH'(in_i.max_bps);
    end
  end

  // Event evaluation
  bpc_core #(
    .RATE_WIDTH (RATE_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .func_i       (func_q),
    .now_i        (now_q),
    .est_i        (est_q),
    .min_i        (min_q),
    .start_i      (start_q),
    .max_i        (max_q),
    .phase_i      (phase_q),
    .further_i    (further_q),
    .probe_time_i (probe_time_q),
    .last_est_i   (last_est_q),
    .start_rate_i (start_rate_q),
    .max_rate_i   (max_rate_q),
    .drop_time_i  (drop_time_q),
    .drop_prior_i (drop_prior_q),
    .phase_o      (phase_d),
    .further_o    (further_d),
    .probe_time_o (probe_time_d),
    .last_est_o   (last_est_d),
    .start_rate_o (start_rate_d),
    .max_rate_o   (max_rate_d),
    .drop_time_o  (drop_time_d),
    .drop_prior_o (drop_prior_d),
    .flags_o      (flags_d),
    .probe_o      (probe_d)
  );

  // Commit state on each evaluated event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_INIT;
      further_q    <= '0;
      probe_time_q <= '0;
      last_est_q   <= '0;
      start_rate_q <= '0;
      max_rate_q   <= '0;
      drop_time_q  <= '0;
      drop_prior_q <= '0;
    end else if (fire) begin
      phase_q      <= phase_d;
      further_q    <= further_d;
      probe_time_q <= probe_time_d;
      last_est_q   <= last_est_d;
      start_rate_q <= start_rate_d;
      max_rate_q   <= max_rate_d;
      drop_time_q  <= drop_time_d;
      drop_prior_q <= drop_prior_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      flags_q <= flags_d;
      probe_q <= probe_d;
    end
  end

  // Drive the result channel; phase and drop record come from the state
  assign out_o.valid          = out_vld_q;
  assign out_o.probe_valid    = flags_q.probe_valid;
  assign out_o.probe_bps      = flags_q.probe_valid ? FieldW'(probe_q) : '0;
  assign out_o.status         = flags_q.status;
  assign out_o.phase_now      = phase_q;
  assign out_o.drop_time_ms   = FieldW'(drop_time_q);
  assign out_o.drop_prior_bps = FieldW'(drop_prior_q);

endmodule

// ===== design/bpc_core.sv =====
// ----------------------------------------------------------------------------
// bpc_core: next-state and result logic of the probe controller
// Evaluates one event against the current state in a single combinational pass.
// ----------------------------------------------------------------------------
module bpc_core import bpc_pkg::*; #(
  parameter int unsigned RATE_WIDTH = 32,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  func_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [RATE_WIDTH-1:0] est_i,
  input  logic [RATE_WIDTH-1:0] min_i,
  input  logic [RATE_WIDTH-1:0] start_i,
  input  logic [RATE_WIDTH-1:0] max_i,
  // current state
  input  phase_e                phase_i,
  input  logic [RATE_WIDTH-1:0] further_i,
  input  logic [TIME_WIDTH-1:0] probe_time_i,
  input  logic [RATE_WIDTH-1:0] last_est_i,
  input  logic [RATE_WIDTH-1:0] start_rate_i,
  input  logic [RATE_WIDTH-1:0] max_rate_i,
  input  logic [TIME_WIDTH-1:0] drop_time_i,
  input  logic [RATE_WIDTH-1:0] drop_prior_i,
  // next state
  output phase_e                phase_o,
  output logic [RATE_WIDTH-1:0] further_o,
  output logic [TIME_WIDTH-1:0] probe_time_o,
  output logic [RATE_WIDTH-1:0] last_est_o,
  output logic [RATE_WIDTH-1:0] start_rate_o,
  output logic [RATE_WIDTH-1:0] max_rate_o,
  output logic [TIME_WIDTH-1:0] drop_time_o,
  output logic [RATE_WIDTH-1:0] drop_prior_o,
  // result
  output bpc_flags_t            flags_o,
  output logic [RATE_WIDTH-1:0] probe_o
);

  localparam int unsigned MulW = RATE_WIDTH + 7;

  logic [RATE_WIDTH-1:0] max_n;
  logic [RATE_WIDTH-1:0] cap;
  logic                  launch_req;
  logic [RATE_WIDTH:0]   launch_rate;
  logic                  launch_further;
  logic                  clamp;
  logic                  launch_go;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  timeout;
  logic                  further_hit;
  logic                  drop_hit;
  logic [MulW-1:0]       est_x;
  logic [MulW-1:0]       fur_x;
  logic [MulW-1:0]       last_x;

  // Max rate after the event sets the probe cap
  assign max_n = (func_i == FUNC_LIMITS) ? max_i : max_rate_i;
  assign cap   = (max_n != '0) ? max_n : RATE_WIDTH'(DefaultMaxBps);

  // Timeout and further-probe tests: est > floor(0.7 r) iff 10 est > 7 r
  assign est_x       = MulW'(est_i);
  assign fur_x       = MulW'(further_i);
  assign last_x      = MulW'(last_est_i);
  assign elapsed     = now_i - probe_time_i;
  assign timeout     = elapsed > TIME_WIDTH'(WaitTimeoutMs);
  assign further_hit = (further_i >= RATE_WIDTH'(2)) &&
                       (est_x * MulW'(FurtherDen) > fur_x * MulW'(FurtherNum));
  assign drop_hit    = est_x * MulW'(DropDen) < last_x * MulW'(DropNum);

  // Select which probe request this event raises
  always_comb begin
    launch_req     = 1'b0;
    launch_rate    = '0;
    launch_further = 1'b0;
    if (func_i == FUNC_LIMITS) begin
      case (phase_i)
        PH_INIT: begin
          launch_req     = (start_rate_o != '0);
          launch_rate    = {1'b0, start_rate_o};
          launch_further = 1'b1;
        end
        PH_DONE: begin
          launch_req     = (last_est_o != '0) && (max_rate_i < max_i) &&
                           (last_est_o < max_i);
          launch_rate    = {1'b0, max_i};
          launch_further = 1'b0;
        end
        default: begin
          launch_req = 1'b0;
        end
      endcase
    end else if (phase_i == PH_WAIT && !timeout && further_hit) begin
      launch_req     = 1'b1;
      launch_rate    = {est_i, 1'b0};
      launch_further = 1'b1;
    end
  end

  // Clamp the probe to the cap; clamping ends probing
  assign clamp     = launch_rate > {1'b0, cap};
  assign launch_go = launch_req && (launch_rate != '0);
  assign probe_o   = clamp ? cap : launch_rate[RATE_WIDTH-1:0];

  // Limits and estimate bookkeeping
  always_comb begin
    start_rate_o = start_rate_i;
    last_est_o   = last_est_i;
    drop_time_o  = drop_time_i;
    drop_prior_o = drop_prior_i;
    max_rate_o   = max_n;
    if (func_i == FUNC_LIMITS) begin
      if (start_i != '0) begin
        start_rate_o = start_i;
        last_est_o   = start_i;
      end else begin
        start_rate_o = min_i;
      end
    end else begin
      if (drop_hit) begin
        drop_time_o  = now_i;
        drop_prior_o = last_est_i;
      end
      last_est_o = est_i;
    end
  end

  // Phase, threshold and probe time
  always_comb begin
    phase_o      = phase_i;
    further_o    = further_i;
    probe_time_o = probe_time_i;
    if (func_i == FUNC_ESTIMATE && phase_i == PH_WAIT && timeout) begin
      phase_o   = PH_DONE;
      further_o = '0;
    end
    if (launch_go) begin
      probe_time_o = now_i;
      if (launch_further && !clamp) begin
        phase_o   = PH_WAIT;
        further_o = launch_rate[RATE_WIDTH-1:0];
      end else begin
        phase_o   = PH_DONE;
        further_o = '0;
      end
    end
  end

  // Result flags
  always_comb begin
    flags_o.probe_valid = launch_go;
    flags_o.status      = (func_i == FUNC_LIMITS) && (phase_i == PH_INIT) &&
                          (start_rate_o == '0);
  end

endmodule
